### hw/rtl/lcdms_pkg.sv
// ----------------------------------------------------------------------------
// lcdms_pkg
// types and constants shared by the lcd mode and line sequencer
// ----------------------------------------------------------------------------
package lcdms_pkg;

	localparam int TICK_W  = 10;
	localparam int LINE_W  = 8;
	localparam int TOTAL_W = 32;
	localparam int MODE_W  = 2;
	localparam int M_W     = 4;
	localparam int T_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// display modes
	localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HBLANK_END   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_END = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VBLANK_LINE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_VISIBLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME   = 3'd5;

	typedef struct packed {
		logic [TICK_W-1:0] hblank_end_ticks;
		logic [TICK_W-1:0] search_end_ticks;
		logic [TICK_W-1:0] transfer_end_ticks;
		logic [TICK_W-1:0] vblank_line_ticks;
		logic [LINE_W-1:0] last_visible_line;
		logic [LINE_W-1:0] last_frame_line;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		hblank_end_ticks:   10'd203,
		search_end_ticks:   10'd80,
		transfer_end_ticks: 10'd172,
		vblank_line_ticks:  10'd456,
		last_visible_line:  8'd143,
		last_frame_line:    8'd153
	};

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [LINE_W-1:0]  line;
		logic [TICK_W-1:0]  ticks;
		logic [TOTAL_W-1:0] machine_total;
		logic [TOTAL_W-1:0] clock_total;
	} seq_state_t;

endpackage

### hw/rtl/lcd_mode_line_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_sequencer
// lcd mode and line sequencer driven by retired instruction costs
// ----------------------------------------------------------------------------
// path: accepted words pass the input register, then the state register
// throughput: one word per cycle when the output does not stall; the state
//   feeds back through one step of adds and compares and so sets the rate
// reset: arst_n clears the state, the totals and both valid flags at once,
//   and loads the registers with their default thresholds
module lcd_mode_line_sequencer import lcdms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// instruction cost words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [M_W-1:0]        m_cycles,
	input  logic [T_W-1:0]        t_cycles,
	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MODE_W-1:0]     mode,
	output logic [LINE_W-1:0]     line,
	output logic [TICK_W-1:0]     line_ticks,
	output logic [TOTAL_W-1:0]    total_machine,
	output logic [TOTAL_W-1:0]    total_clock
);

	cfg_t             cfg_q;
	seq_state_t       state_q;
	seq_state_t       state_nxt;
	logic             valid_s1;
	logic [M_W-1:0]   m_s1;
	logic [T_W-1:0]   t_s1;
	logic             out_valid_q;
	logic             advance;
	logic             in_take;

	// configuration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HBLANK_END:   cfg_q.hblank_end_ticks   <= cfg_data;
				REG_SEARCH_END:   cfg_q.search_end_ticks   <= cfg_data;
				REG_TRANSFER_END: cfg_q.transfer_end_ticks <= cfg_data;
				REG_VBLANK_LINE:  cfg_q.vblank_line_ticks  <= cfg_data;
				REG_LAST_VISIBLE: cfg_q.last_visible_line  <= cfg_data[LINE_W-1:0];
				REG_LAST_FRAME:   cfg_q.last_frame_line    <= cfg_data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// the input stage moves on whenever the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			m_s1 <= m_cycles;
			t_s1 <= t_cycles;
		end
	end

	lcdms_step u_step (
		.cfg      (cfg_q),
		.cur      (state_q),
		.m_cycles (m_s1),
		.t_cycles (t_s1),
		.nxt      (state_nxt)
	);

	// the sequencer state doubles as the result register: it only steps when
	// the previous result has gone, so the shown word holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = state_q.mode;
	assign line          = state_q.line;
	assign line_ticks    = state_q.ticks;
	assign total_machine = state_q.machine_total;
	assign total_clock   = state_q.clock_total;

endmodule

### hw/rtl/lcdms_step.sv
// ----------------------------------------------------------------------------
// lcdms_step
// next-state logic of the sequencer for one instruction word
// ----------------------------------------------------------------------------
module lcdms_step import lcdms_pkg::*; (
	input  cfg_t             cfg,
	input  seq_state_t       cur,
	input  logic [M_W-1:0]   m_cycles,
	input  logic [T_W-1:0]   t_cycles,
	output seq_state_t       nxt
);

	logic [TICK_W:0]   tick_sum;
	logic [TICK_W-1:0] ticks_sat;
	logic [LINE_W-1:0] line_inc;

	assign tick_sum  = {1'b0, cur.ticks} + {{(TICK_W+1-M_W){1'b0}}, m_cycles};
	assign ticks_sat = tick_sum[TICK_W] ? TICK_MAX : tick_sum[TICK_W-1:0];
	assign line_inc  = cur.line + LINE_W'(1);

	always_comb begin
		nxt.mode          = cur.mode;
		nxt.line          = cur.line;
		nxt.ticks         = ticks_sat;
		nxt.machine_total = cur.machine_total + {{(TOTAL_W-M_W){1'b0}}, m_cycles};
		nxt.clock_total   = cur.clock_total + {{(TOTAL_W-T_W){1'b0}}, t_cycles};
		unique case (cur.mode)
			MODE_HBLANK: begin
				if (ticks_sat > cfg.hblank_end_ticks) begin
					nxt.mode  = (cur.line == cfg.last_visible_line) ? MODE_VBLANK : MODE_SEARCH;
					nxt.ticks = '0;
					nxt.line  = line_inc;
				end
			end
			MODE_VBLANK: begin
				if (ticks_sat >= cfg.vblank_line_ticks) begin
					nxt.ticks = '0;
					if (cur.line == cfg.last_frame_line) begin
						nxt.mode          = MODE_SEARCH;
						nxt.line          = '0;
						nxt.machine_total = '0;
					end else begin
						nxt.line = line_inc;
					end
				end
			end
			MODE_SEARCH: begin
				if (ticks_sat > cfg.search_end_ticks) begin
					nxt.mode  = MODE_TRANSFER;
					nxt.ticks = '0;
				end
			end
			default: begin
				if (ticks_sat > cfg.transfer_end_ticks) begin
					nxt.mode  = MODE_HBLANK;
					nxt.ticks = '0;
				end
			end
		endcase
	end

endmodule

### hw/rtl/lcdms_checker.sv
// ----------------------------------------------------------------------------
// lcdms_checker
// port-level checks on the lcd mode and line sequencer
// ----------------------------------------------------------------------------
module lcdms_checker import lcdms_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [MODE_W-1:0]     mode,
	input logic [LINE_W-1:0]     line,
	input logic [TICK_W-1:0]     line_ticks,
	input logic [TOTAL_W-1:0]    total_machine,
	input logic [TOTAL_W-1:0]    total_clock
);

	logic              have_prev_q;
	logic [MODE_W-1:0] prev_mode_q;

	// mode of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_mode_q <= MODE_HBLANK;
		end else if (out_valid && !out_stall) begin
			have_prev_q <= 1'b1;
			prev_mode_q <= mode;
		end
	end

	// no result survives reset
	a_reset_clears: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// a held result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode) && $stable(line)
			&& $stable(line_ticks) && $stable(total_machine) && $stable(total_clock))
		else $error("stalled result changed");

	// input back-pressure only ever comes from a stalled full output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a change of mode always starts the tick count afresh
	a_mode_change_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q && (mode != prev_mode_q) |-> line_ticks == '0)
		else $error("mode changed without clearing ticks");

endmodule

bind lcd_mode_line_sequencer lcdms_checker u_lcdms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.mode          (mode),
	.line          (line),
	.line_ticks    (line_ticks),
	.total_machine (total_machine),
	.total_clock   (total_clock)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lcd mode and line sequencer: a queue-fed
// driver sends instruction cost words and a monitor checks every result
// word against a local model of the mode, line, tick and total state
// ----------------------------------------------------------------------------
module testbench;
	import lcdms_pkg::*;

	// cycles with no word moving on either side before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// quiet cycles after the last result
	localparam int SETTLE_CYCLES  = 4;

	// indexes with no register behind them, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [M_W-1:0] m;
		logic [T_W-1:0] t;
	} cost_word_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [M_W-1:0]        m_cycles  = '0;
	logic [T_W-1:0]        t_cycles  = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [MODE_W-1:0]     mode;
	logic [LINE_W-1:0]     line;
	logic [TICK_W-1:0]     line_ticks;
	logic [TOTAL_W-1:0]    total_machine;
	logic [TOTAL_W-1:0]    total_clock;

	// words waiting to be sent and status words waiting to come back
	cost_word_t  pending_words[$];
	seq_state_t  awaited_status[$];
	cost_word_t  next_word;
	seq_state_t  oldest_status;

	// local copy of the sequencer registers and state
	cfg_t        model_cfg = CFG_RESET;
	seq_state_t  model_seq = '0;

	logic        word_taken   = 1'b0;
	int unsigned words_queued = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles  = 0;
	int unsigned error_count  = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lcd_mode_line_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.m_cycles      (m_cycles),
		.t_cycles      (t_cycles),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mode          (mode),
		.line          (line),
		.line_ticks    (line_ticks),
		.total_machine (total_machine),
		.total_clock   (total_clock)
	);

	// one sequencer step for one accepted cost word, returns the status word
	function automatic seq_state_t step_sequencer(input logic [M_W-1:0] m,
			input logic [T_W-1:0] t);
		logic [TICK_W:0] tick_sum;
		model_seq.machine_total = model_seq.machine_total + TOTAL_W'(m);
		model_seq.clock_total   = model_seq.clock_total + TOTAL_W'(t);
		// tick counter saturates rather than wrapping
		tick_sum = {1'b0, model_seq.ticks} + (TICK_W+1)'(m);
		model_seq.ticks = (tick_sum > TICK_MAX) ? TICK_MAX : tick_sum[TICK_W-1:0];
		case (model_seq.mode)
			MODE_HBLANK: begin
				if (model_seq.ticks > model_cfg.hblank_end_ticks) begin
					model_seq.mode = (model_seq.line == model_cfg.last_visible_line) ?
						MODE_VBLANK : MODE_SEARCH;
					model_seq.ticks = '0;
					model_seq.line  = model_seq.line + LINE_W'(1);
				end
			end
			MODE_VBLANK: begin
				// greater-or-equal here, so a zero threshold ends a line every step
				if (model_seq.ticks >= model_cfg.vblank_line_ticks) begin
					model_seq.ticks = '0;
					if (model_seq.line == model_cfg.last_frame_line) begin
						// frame wrap also clears the machine-cycle total
						model_seq.mode          = MODE_SEARCH;
						model_seq.line          = '0;
						model_seq.machine_total = '0;
					end else begin
						model_seq.line = model_seq.line + LINE_W'(1);
					end
				end
			end
			MODE_SEARCH: begin
				if (model_seq.ticks > model_cfg.search_end_ticks) begin
					model_seq.mode  = MODE_TRANSFER;
					model_seq.ticks = '0;
				end
			end
			default: begin
				if (model_seq.ticks > model_cfg.transfer_end_ticks) begin
					model_seq.mode  = MODE_HBLANK;
					model_seq.ticks = '0;
				end
			end
		endcase
		return model_seq;
	endfunction

	task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want,
			input logic [TOTAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// monitor: checks result words, tracks register writes and predicts
	// the status for every accepted cost word, all at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_status.size() == 0) begin
					$display("%0t: result word with none awaited, actual mode %0d line %0d",
						$time, mode, line);
					error_count++;
				end else begin
					oldest_status = awaited_status.pop_front();
					compare_field("mode", TOTAL_W'(oldest_status.mode), TOTAL_W'(mode));
					compare_field("line", TOTAL_W'(oldest_status.line), TOTAL_W'(line));
					compare_field("line_ticks", TOTAL_W'(oldest_status.ticks),
						TOTAL_W'(line_ticks));
					compare_field("total_machine", oldest_status.machine_total,
						total_machine);
					compare_field("total_clock", oldest_status.clock_total, total_clock);
				end
				results_seen++;
			end
			// register writes only happen while idle, so order against steps is moot
			if (cfg_we) begin
				case (cfg_index)
					REG_HBLANK_END:   model_cfg.hblank_end_ticks   = cfg_data;
					REG_SEARCH_END:   model_cfg.search_end_ticks   = cfg_data;
					REG_TRANSFER_END: model_cfg.transfer_end_ticks = cfg_data;
					REG_VBLANK_LINE:  model_cfg.vblank_line_ticks  = cfg_data;
					REG_LAST_VISIBLE: model_cfg.last_visible_line  = cfg_data[LINE_W-1:0];
					REG_LAST_FRAME:   model_cfg.last_frame_line    = cfg_data[LINE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				awaited_status.push_back(step_sequencer(m_cycles, t_cycles));
			word_taken <= in_valid && !in_stall;
			// watchdog on traffic in either direction
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// driver: presents the next pending word once the previous one was taken,
	// and drives the result-side stall, both on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					m_cycles <= next_word.m;
					t_cycles <= next_word.t;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_word(input logic [M_W-1:0] m, input logic [T_W-1:0] t);
		cost_word_t w;
		w.m = m;
		w.t = t;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// random costs, leaning a little on zero and full machine-cycle counts
	// so that held modes and tick saturation both show up
	task automatic queue_random(input int count);
		logic [M_W-1:0] m;
		int unsigned    pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			if (pick == 0)
				m = '0;
			else if (pick == 1)
				m = '1;
			else
				m = M_W'($urandom_range(15));
			queue_word(m, T_W'($urandom_range(255)));
		end
	endtask

	// blocks until every queued word has produced its result
	task automatic wait_idle();
		while (results_seen != words_queued)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// rewrites all six registers, then lines up on a rising edge for refill
	task automatic program_regs(input logic [CFG_DATA_W-1:0] hblank_end,
			input logic [CFG_DATA_W-1:0] search_end,
			input logic [CFG_DATA_W-1:0] transfer_end,
			input logic [CFG_DATA_W-1:0] vblank_line,
			input logic [CFG_DATA_W-1:0] last_visible,
			input logic [CFG_DATA_W-1:0] last_frame);
		write_reg(REG_HBLANK_END, hblank_end);
		write_reg(REG_SEARCH_END, search_end);
		write_reg(REG_TRANSFER_END, transfer_end);
		write_reg(REG_VBLANK_LINE, vblank_line);
		write_reg(REG_LAST_VISIBLE, last_visible);
		write_reg(REG_LAST_FRAME, last_frame);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// idling pattern per phase: none, sender gaps, receiver stalls, both
	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 60; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 60; end
			default: begin send_idle_pct = 25; stall_pct = 25; end
		endcase
	endtask

	// mostly small thresholds so modes turn over, now and then anywhere
	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		if ($urandom_range(3) == 0)
			return CFG_DATA_W'($urandom_range(1023));
		return CFG_DATA_W'($urandom_range(40));
	endfunction

	initial begin
		logic [LINE_W-1:0] here;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset thresholds: field extremes and every bit of both costs
		queue_word(4'd0, 8'd0);
		queue_word(4'd15, 8'd255);
		queue_word(4'd15, 8'd0);
		queue_word(4'd0, 8'd255);
		queue_word(4'd5, 8'd170);
		queue_word(4'd10, 8'd85);
		queue_word(4'd1, 8'd1);
		queue_word(4'd8, 8'd128);
		queue_word(4'd7, 8'd127);
		queue_word(4'd3, 8'd64);
		wait_idle();

		// writes to unmapped indexes must change nothing
		write_reg(REG_UNMAPPED_LO, 10'h3ff);
		write_reg(REG_UNMAPPED_HI, 10'h000);
		// zero thresholds, visible line written with high bits that get masked,
		// two-line vblank so a frame wrap comes within a few words
		program_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'h300, 10'd2);
		queue_word(4'd0, 8'd9);    // carried ticks end the last visible hblank
		queue_word(4'd1, 8'd200);  // zero vblank threshold ends a line at once
		queue_word(4'd0, 8'd17);   // last frame line, wrap and total clear
		queue_word(4'd0, 8'd33);   // zero ticks never pass a zero threshold
		queue_word(4'd0, 8'd2);
		queue_word(4'd2, 8'd99);
		queue_word(4'd15, 8'd250);
		queue_word(4'd1, 8'd4);
		queue_word(4'd0, 8'd0);
		queue_word(4'd0, 8'd255);
		wait_idle();

		// reset values written back explicitly
		set_idling(1);
		program_regs(CFG_RESET.hblank_end_ticks, CFG_RESET.search_end_ticks,
			CFG_RESET.transfer_end_ticks, CFG_RESET.vblank_line_ticks,
			CFG_DATA_W'(CFG_RESET.last_visible_line),
			CFG_DATA_W'(CFG_RESET.last_frame_line));
		queue_random(100);
		wait_idle();

		// short lines and frames, many wraps
		set_idling(2);
		program_regs(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(15)),
			CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(15)),
			CFG_DATA_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(15)));
		queue_random(150);
		wait_idle();

		// line counter overflow: vblank starts just past the current line and
		// runs through 255 back round to it, one line per word
		set_idling(3);
		here = model_seq.line;
		if (model_seq.mode == MODE_VBLANK)
			program_regs(10'd0, 10'd0, 10'd0, 10'd0, CFG_DATA_W'(here),
				CFG_DATA_W'(here - LINE_W'(1)));
		else
			program_regs(10'd0, 10'd0, 10'd0, 10'd0, CFG_DATA_W'(here),
				CFG_DATA_W'(here));
		queue_random(280);
		wait_idle();

		// top thresholds: modes hold, ticks saturate, vblank ends at saturation
		set_idling(0);
		program_regs(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff,
			CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)));
		queue_random(160);
		wait_idle();

		// random settings
		set_idling(1);
		program_regs(pick_threshold(), pick_threshold(), pick_threshold(),
			pick_threshold(), CFG_DATA_W'($urandom_range(1023)),
			CFG_DATA_W'($urandom_range(1023)));
		queue_random(150);
		wait_idle();

		// zero thresholds with top line numbers
		set_idling(2);
		program_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'h0ff, 10'h0ff);
		queue_random(100);
		wait_idle();

		set_idling(3);
		program_regs(pick_threshold(), pick_threshold(), pick_threshold(),
			pick_threshold(), CFG_DATA_W'($urandom_range(1023)),
			CFG_DATA_W'($urandom_range(1023)));
		queue_random(100);
		wait_idle();

		// back to the reset settings to finish
		set_idling(0);
		program_regs(CFG_RESET.hblank_end_ticks, CFG_RESET.search_end_ticks,
			CFG_RESET.transfer_end_ticks, CFG_RESET.vblank_line_ticks,
			CFG_DATA_W'(CFG_RESET.last_visible_line),
			CFG_DATA_W'(CFG_RESET.last_frame_line));
		queue_random(50);
		wait_idle();

		if (error_count == 0 && awaited_status.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
